FILE: design/aarr_pkg.sv
// ----------------------------------------------------------------------------
// aarr_pkg
// Shared types and constants of the annular arc row rasterizer: register set,
// row job record, pipeline beat and the sine/cosine threshold tables.
// ----------------------------------------------------------------------------
package aarr_pkg;

  // Signed width of internal screen coordinates.
  localparam int CW = 12;
  typedef logic signed [CW-1:0] coord_t;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_CENTER_X     = 3'd0;
  localparam logic [2:0] REG_CENTER_Y     = 3'd1;
  localparam logic [2:0] REG_INNER_RADIUS = 3'd2;
  localparam logic [2:0] REG_OUTER_RADIUS = 3'd3;
  localparam logic [2:0] REG_START_ANGLE  = 3'd4;
  localparam logic [2:0] REG_END_ANGLE    = 3'd5;
  localparam logic [2:0] REG_PIXEL_COLOR  = 3'd6;

  typedef struct packed {
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [6:0]  inner_radius;
    logic [6:0]  outer_radius;
    logic [8:0]  start_angle;
    logic [9:0]  end_angle;
    logic [15:0] pixel_color;
  } cfg_t;

  // One row that survived the setup checks.
  typedef struct packed {
    logic [7:0]        row;
    logic signed [7:0] dy;
    logic [6:0]        dxi;
    coord_t            rx0;
    coord_t            rx1;
  } job_t;

  // Beat kinds in the pixel pipeline.
  localparam logic [1:0] KIND_PIX   = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    coord_t     x;
    logic [7:0] row;
    logic [7:0] ax;
    logic [7:0] ay;
    logic       neg_x;
    logic       pos_y;
    logic       far;
    logic [6:0] cnt;
  } beat_t;

  // Number of half-degree thresholds in one quadrant and search depth.
  localparam int NK     = 90;
  localparam int NSRCH  = 7;
  localparam int MAX_RUNS = 4;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [NK-1:0][30:0] trig_tab_t;

  // Q30 sine or cosine of (k + 0.5) degrees by an 11-term series.
  function automatic trig_tab_t build_trig(input bit want_cos);
    trig_tab_t   tab;
    logic [63:0] x, x2, ts, tc, s, c;
    for (int k = 0; k < NK; k++) begin
      x  = (PI_Q30 * 64'(2 * k + 1)) / 64'd360;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s  = x;
      c  = 64'd1 << 30;
      for (int n = 1; n <= 10; n++) begin
        ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n & 1) == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      tab[k] = want_cos ? c[30:0] : s[30:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b1);
  localparam trig_tab_t SIN_TAB = build_trig(1'b0);

endpackage

FILE: design/aarr_queue.sv
// ----------------------------------------------------------------------------
// aarr_queue
// Two-entry queue of row jobs between the setup front and the pixel back.
// ----------------------------------------------------------------------------
module aarr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aarr_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output aarr_pkg::job_t dout,
  output logic          empty
);
  import aarr_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

FILE: design/aarr_front.sv
// ----------------------------------------------------------------------------
// aarr_front
// Accepts a row, clips it against the outer circle's box and finds the outer
// and inner half-widths with one shared bit-serial square root.
// ----------------------------------------------------------------------------
module aarr_front #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic           clk,
  input  logic           rst,
  input  aarr_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_row,
  output logic           push,
  output aarr_pkg::job_t job,
  input  logic           q_full
);
  import aarr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SQO   = 3'd2;
  localparam logic [2:0] ST_SQI   = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0]        state;
  logic [7:0]        row_r;
  logic signed [7:0] dy_r;
  logic [13:0]       dysq_r;
  logic [13:0]       sq_v;
  logic [6:0]        root;
  logic [2:0]        bitpos;
  logic [6:0]        dxo_r;
  logic [6:0]        dxi_r;

  coord_t cx, cy, ro, rw;
  coord_t y0, y1, x0, x1, dy_w, rx0, rx1;
  logic   ok;
  logic [13:0] ro_sq, ri_sq;
  logic [6:0]  trial;
  logic [6:0]  root_next;

  always_comb begin
    cx = coord_t'({4'd0, cfg.center_x});
    cy = coord_t'({4'd0, cfg.center_y});
    ro = coord_t'({5'd0, cfg.outer_radius});
    rw = coord_t'({4'd0, row_r});
    y0 = cy - ro;
    if (y0 < 0) y0 = '0;
    y1 = cy + ro;
    if (y1 > coord_t'(SCREEN_HEIGHT - 1)) y1 = coord_t'(SCREEN_HEIGHT - 1);
    x0 = cx - ro;
    if (x0 < 0) x0 = '0;
    x1 = cx + ro;
    if (x1 > coord_t'(SCREEN_WIDTH - 1)) x1 = coord_t'(SCREEN_WIDTH - 1);
    ok = (cfg.outer_radius != 7'd0) && ({1'b0, cfg.start_angle} < cfg.end_angle) &&
         (x1 >= x0) && (y1 >= y0) && (rw >= y0) && (rw <= y1);
    dy_w   = rw - cy;
    ro_sq  = 14'(cfg.outer_radius) * 14'(cfg.outer_radius);
    ri_sq  = 14'(cfg.inner_radius) * 14'(cfg.inner_radius);
    trial  = root | (7'd1 << bitpos);
    root_next = ((14'(trial) * 14'(trial)) <= sq_v) ? trial : root;
    rx0 = cx - coord_t'({5'd0, dxo_r});
    if (rx0 < 0) rx0 = '0;
    rx1 = cx + coord_t'({5'd0, dxo_r});
    if (rx1 > coord_t'(SCREEN_WIDTH - 1)) rx1 = coord_t'(SCREEN_WIDTH - 1);
  end

  // The square of a signed offset equals the square of its magnitude.
  logic [7:0] ady;
  assign ady = dy_w[CW-1] ? 8'(-dy_w) : dy_w[7:0];

  assign in_ready = (state == ST_IDLE);
  assign push     = (state == ST_PUSH) && !q_full && (rx1 >= rx0);
  assign job      = '{row: row_r, dy: dy_r, dxi: dxi_r, rx0: rx0, rx1: rx1};

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) row_r <= in_row;
      end
      ST_CHECK: begin
        dy_r   <= dy_w[7:0];
        dysq_r <= 14'(ady) * 14'(ady);
        sq_v   <= ro_sq - (14'(ady) * 14'(ady));
        root   <= '0;
        bitpos <= 3'd6;
      end
      ST_SQO: begin
        if (bitpos == 3'd0) begin
          dxo_r  <= root_next;
          root   <= '0;
          bitpos <= 3'd6;
          sq_v   <= (dysq_r < ri_sq) ? ri_sq - dysq_r : '0;
        end else begin
          root   <= root_next;
          bitpos <= bitpos - 3'd1;
        end
      end
      ST_SQI: begin
        root   <= root_next;
        bitpos <= bitpos - 3'd1;
        if (bitpos == 3'd0) dxi_r <= root_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (in_valid) state <= ST_CHECK;
        ST_CHECK: state <= ok ? ST_SQO : ST_IDLE;
        ST_SQO:   if (bitpos == 3'd0) state <= ST_SQI;
        ST_SQI:   if (bitpos == 3'd0) state <= ST_PUSH;
        ST_PUSH:  if (!q_full || rx1 < rx0) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/aarr_back.sv
// ----------------------------------------------------------------------------
// aarr_back
// Sweeps the columns of each queued row through an angle pipeline (a binary
// search over the quadrant thresholds) and joins included pixels into runs.
// ----------------------------------------------------------------------------
module aarr_back #(
  parameter int TABLE_SPAN = 101
) (
  input  logic            clk,
  input  logic            rst,
  input  aarr_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  aarr_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [39:0]     m_data,
  output logic            m_last
);
  import aarr_pkg::*;

  localparam coord_t SPAN_MAX = coord_t'(TABLE_SPAN - 1);

  logic en;
  assign en = !m_valid || m_ready;

  // Column sweep.
  logic       active;
  logic [1:0] kind;
  coord_t     x;
  job_t       cur;

  assign q_pop = en && !active && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
    if (en) begin
      if (q_pop) begin
        x <= q_job.rx0;
      end else if (active && kind == KIND_PIX && x != cur.rx1) begin
        x <= x + coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      kind   <= KIND_PIX;
    end else if (en) begin
      if (q_pop) begin
        active <= 1'b1;
        kind   <= KIND_PIX;
      end else if (active) begin
        case (kind)
          KIND_PIX:   if (x == cur.rx1) kind <= KIND_CLOSE;
          KIND_CLOSE: kind <= KIND_FLUSH;
          default:    active <= 1'b0;
        endcase
      end
    end
  end

  // First stage: offsets, magnitudes and the inner-circle test.
  beat_t  pipe [NSRCH+1];
  coord_t dx, adx, dyw, ady;

  always_comb begin
    dx  = x - coord_t'({4'd0, cfg.center_x});
    adx = (dx < 0) ? -dx : dx;
    dyw = coord_t'(cur.dy);
    ady = (dyw < 0) ? -dyw : dyw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].vld <= 1'b0;
    end else if (en) begin
      pipe[0].vld <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].kind  <= kind;
      pipe[0].x     <= x;
      pipe[0].row   <= cur.row;
      pipe[0].ax    <= (adx > SPAN_MAX) ? SPAN_MAX[7:0] : adx[7:0];
      pipe[0].ay    <= (ady > SPAN_MAX) ? SPAN_MAX[7:0] : ady[7:0];
      pipe[0].neg_x <= dx < 0;
      pipe[0].pos_y <= dyw > 0;
      pipe[0].far   <= adx >= coord_t'({5'd0, cur.dxi});
      pipe[0].cnt   <= '0;
    end
  end

  // Search stages: each decides one bit of the quadrant angle.
  for (genvar j = 0; j < NSRCH; j++) begin : g_srch
    localparam int STEP = 64 >> j;
    logic [7:0]  cand;
    logic        ok;
    logic [6:0]  idx;
    logic [38:0] lhs, rhs;

    always_comb begin
      cand = {1'b0, pipe[j].cnt} + 8'(STEP);
      ok   = cand <= 8'(NK);
      idx  = ok ? 7'(cand - 8'd1) : 7'd0;
      lhs  = 39'(pipe[j].ax) * 39'(COS_TAB[idx]);
      rhs  = 39'(pipe[j].ay) * 39'(SIN_TAB[idx]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[j+1].vld <= 1'b0;
      end else if (en) begin
        pipe[j+1].vld <= pipe[j].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[j+1].kind  <= pipe[j].kind;
        pipe[j+1].x     <= pipe[j].x;
        pipe[j+1].row   <= pipe[j].row;
        pipe[j+1].ax    <= pipe[j].ax;
        pipe[j+1].ay    <= pipe[j].ay;
        pipe[j+1].neg_x <= pipe[j].neg_x;
        pipe[j+1].pos_y <= pipe[j].pos_y;
        pipe[j+1].far   <= pipe[j].far;
        pipe[j+1].cnt   <= (ok && lhs > rhs) ? pipe[j].cnt + 7'(STEP) : pipe[j].cnt;
      end
    end
  end

  // Tail: full-circle angle, range test and run building.
  beat_t      t;
  logic [9:0] q, ang;
  logic       in_rng, inc;

  always_comb begin
    t = pipe[NSRCH];
    q = {3'd0, t.cnt};
    if (!t.pos_y) begin
      ang = t.neg_x ? ((q == 10'd0) ? 10'd0 : 10'd360 - q) : q;
    end else begin
      ang = t.neg_x ? 10'd180 + q : 10'd180 - q;
    end
    if (cfg.end_angle <= 10'd360) begin
      in_rng = (ang >= {1'b0, cfg.start_angle}) && (ang <= cfg.end_angle);
    end else begin
      in_rng = (ang >= {1'b0, cfg.start_angle}) || (ang <= cfg.end_angle - 10'd360);
    end
    inc = (t.kind == KIND_PIX) && t.far && in_rng;
  end

  logic       run_open;
  logic [7:0] run_first;
  logic       pend_vld;
  logic [7:0] pend_first, pend_last, pend_row;
  logic [2:0] nruns;
  logic       close;
  logic [7:0] close_last;

  always_comb begin
    close      = t.vld && run_open && t.kind != KIND_FLUSH && !inc;
    close_last = (t.kind == KIND_PIX) ? 8'(t.x - coord_t'(1)) : t.x[7:0];
  end

  always_ff @(posedge clk) begin
    if (en && t.vld) begin
      if (inc && !run_open) run_first <= t.x[7:0];
      if (close && nruns < 3'(MAX_RUNS)) begin
        pend_first <= run_first;
        pend_last  <= close_last;
        pend_row   <= t.row;
      end
    end
    if (en && t.vld &&
        ((close && nruns < 3'(MAX_RUNS) && pend_vld) || (t.kind == KIND_FLUSH && pend_vld))) begin
      m_data <= {cfg.pixel_color, pend_last, pend_first, pend_row};
      m_last <= (t.kind == KIND_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
      pend_vld <= 1'b0;
      nruns    <= '0;
      m_valid  <= 1'b0;
    end else begin
      if (m_ready) m_valid <= 1'b0;
      if (en && t.vld) begin
        if (t.kind == KIND_FLUSH) begin
          if (pend_vld) m_valid <= 1'b1;
          pend_vld <= 1'b0;
          run_open <= 1'b0;
          nruns    <= '0;
        end else begin
          if (inc && !run_open) run_open <= 1'b1;
          if (close) begin
            run_open <= 1'b0;
            if (nruns < 3'(MAX_RUNS)) begin
              nruns    <= nruns + 3'd1;
              pend_vld <= 1'b1;
              if (pend_vld) m_valid <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

FILE: design/annular_arc_row_rasterizer_core.sv
// ----------------------------------------------------------------------------
// annular_arc_row_rasterizer_core
// Turns screen rows into pixel runs of a configured annular sector.
// ----------------------------------------------------------------------------
// Usage: write the seven registers on the cfg port while the block is idle,
// then send row numbers on the s_ stream. For each row the block returns the
// maximal runs of covered pixels, left to right, on the m_ stream; m_tlast
// marks the last run of the row. A row that covers nothing returns no beats.
// At most four runs are returned per row.
// Flow: the setup front works on one row at a time (clip check, then a
// 7-step square root for the outer and again for the inner half-width). The
// pixel back sweeps one column per cycle between the clipped edges while the
// output does not stall, then closes and flushes the row; each column passes
// through the registered stages of the angle pipeline. A two-entry row queue
// lets the front prepare the next row while the back sweeps.
// Reset returns the registers to their defaults and empties all stages.
// When m_tvalid is high and m_tready low the whole back pipeline holds; the
// front keeps taking rows until the queue is full.
// ----------------------------------------------------------------------------
module annular_arc_row_rasterizer_core #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240,
  parameter int TABLE_SPAN    = 101
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // run_row, run_x_first, run_x_last, run_color
  output logic        m_tlast    // run_final
);
  import aarr_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{center_x: 8'd120, center_y: 8'd120, inner_radius: 7'd40,
               outer_radius: 7'd100, start_angle: 9'd0, end_angle: 10'd360,
               pixel_color: 16'd0};
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_CENTER_X:     cfg.center_x     <= cfg_wdata[7:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_wdata[7:0];
        REG_INNER_RADIUS: cfg.inner_radius <= cfg_wdata[6:0];
        REG_OUTER_RADIUS: cfg.outer_radius <= cfg_wdata[6:0];
        REG_START_ANGLE:  cfg.start_angle  <= cfg_wdata[8:0];
        REG_END_ANGLE:    cfg.end_angle    <= cfg_wdata[9:0];
        REG_PIXEL_COLOR:  cfg.pixel_color  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic push, q_full, q_empty, q_pop;
  job_t job_in, job_out;

  aarr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_row  (s_tdata),
    .push    (push),
    .job     (job_in),
    .q_full  (q_full)
  );

  aarr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (job_out),
    .empty(q_empty)
  );

  aarr_back #(
    .TABLE_SPAN(TABLE_SPAN)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_empty(q_empty),
    .q_job  (job_out),
    .q_pop  (q_pop),
    .m_valid(m_tvalid),
    .m_ready(m_tready),
    .m_data (m_tdata),
    .m_last (m_tlast)
  );

endmodule
